// ----- src/fcm_pkg.sv -----
// ----------------------------------------------------------------------------
// fcm_pkg
// Shared types, codes and helpers for the allocation table chain manager.
// ----------------------------------------------------------------------------
`default_nettype none

package fcm_pkg;

  // Default table size
  localparam int unsigned DEF_TABLE_ENTRIES = 256;

  // Field widths
  localparam int CMD_W   = 2;
  localparam int BYTE_W  = 8;
  localparam int STAT_W  = 2;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 16;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FREE   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd3;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOFREE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_PAST   = 2'd2;

  // Reset link value of every entry
  localparam logic [BYTE_W-1:0] RESET_LINK = 8'd1;

  // One table entry
  typedef struct packed {
    logic              free_mark;
    logic              end_mark;
    logic [BYTE_W-1:0] next_link;
  } entry_t;

  // Reduce an 8-bit link modulo the table size: eight compare/subtract steps
  function automatic logic [BYTE_W-1:0] wrap_link(input logic [BYTE_W-1:0] v,
                                                  input int unsigned     n);
    int unsigned r;
    r = 32'(v);
    for (int k = BYTE_W - 1; k >= 0; k--) begin
      if (r >= (n << k)) begin
        r = r - (n << k);
      end
    end
    return r[BYTE_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- src/fcm_table.sv -----
// ----------------------------------------------------------------------------
// fcm_table
// Allocation table storage: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module fcm_table
  import fcm_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = DEF_TABLE_ENTRIES,
  localparam int         IW            = $clog2(TABLE_ENTRIES)
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [IW-1:0] wr_addr,
  input  wire entry_t        wr_data,
  input  wire logic          rd_en,
  input  wire logic [IW-1:0] rd_addr,
  output entry_t             rd_data
);

  entry_t mem [TABLE_ENTRIES];
  entry_t rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, data appears in the cycle after rd_en
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- src/fcm_ctrl.sv -----
// ----------------------------------------------------------------------------
// fcm_ctrl
// Command sequencer: clearing pass, free search, chain walks, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fcm_ctrl
  import fcm_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = DEF_TABLE_ENTRIES,
  localparam int         IW            = $clog2(TABLE_ENTRIES)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // command channel
  input  wire logic              cmd_valid,
  output logic                   cmd_ready,
  input  wire logic [CMD_W-1:0]  command,
  input  wire logic [BYTE_W-1:0] chain_head,
  input  wire logic [BYTE_W-1:0] link_count,
  // result channel
  output logic                   res_valid,
  input  wire logic              res_ready,
  output logic [STAT_W-1:0]      status,
  output logic [BYTE_W-1:0]      entry_index,
  // table ports
  output logic                   wr_en,
  output logic [IW-1:0]          wr_addr,
  output entry_t                 wr_data,
  output logic                   rd_en,
  output logic [IW-1:0]          rd_addr,
  input  wire entry_t            rd_data
);

  localparam logic [IW:0]   ENTRIES_W = (IW+1)'(TABLE_ENTRIES);
  localparam logic [IW:0]   LAST_N    = (IW+1)'(TABLE_ENTRIES - 1);
  localparam logic [IW-1:0] LAST_IDX  = IW'(TABLE_ENTRIES - 1);

  // Sequencer states
  localparam logic [2:0] ST_INIT  = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_START = 3'd3;
  localparam logic [2:0] ST_WALK  = 3'd4;
  localparam logic [2:0] ST_FREE  = 3'd5;
  localparam logic [2:0] ST_LOOK  = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  logic [2:0]        state_r, state_nxt;
  logic [CMD_W-1:0]  cmd_r, cmd_nxt;
  logic [IW-1:0]     cur_r, cur_nxt;
  logic [BYTE_W-1:0] cnt_r, cnt_nxt;
  logic [IW:0]       n_r, n_nxt;
  logic [IW:0]       ptr_r, ptr_nxt;
  logic              rvld_r, rvld_nxt;
  logic [IW-1:0]     raddr_r, raddr_nxt;
  logic [IW-1:0]     fresh_r, fresh_nxt;
  logic [IW-1:0]     clr_r, clr_nxt;
  logic [STAT_W-1:0] rstat_r, rstat_nxt;
  logic [BYTE_W-1:0] ridx_r, ridx_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] out_stat_r;
  logic [BYTE_W-1:0] out_idx_r;
  logic              load;

  // Index/byte conversions at any table width
  logic [IW+7:0] next_ext, head_ext, fresh_ext, raddr_ext, cur_next_ext;
  logic [IW-1:0] link_idx, head_idx;

  assign next_ext     = {{IW{1'b0}}, wrap_link(rd_data.next_link, TABLE_ENTRIES)};
  assign head_ext     = {{IW{1'b0}}, wrap_link(chain_head, TABLE_ENTRIES)};
  assign link_idx     = next_ext[IW-1:0];
  assign head_idx     = head_ext[IW-1:0];
  assign fresh_ext    = {8'd0, fresh_r};
  assign raddr_ext    = {8'd0, raddr_r};
  assign cur_next_ext = {8'd0, link_idx};

  assign cmd_ready = (state_r == ST_IDLE);
  assign load      = (state_r == ST_DONE) && (!out_valid_r || res_ready);

  // Next-state and table access logic
  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    cur_nxt   = cur_r;
    cnt_nxt   = cnt_r;
    n_nxt     = n_r;
    ptr_nxt   = ptr_r;
    rvld_nxt  = 1'b0;
    raddr_nxt = raddr_r;
    fresh_nxt = fresh_r;
    clr_nxt   = clr_r;
    rstat_nxt = rstat_r;
    ridx_nxt  = ridx_r;
    wr_en     = 1'b0;
    wr_addr   = cur_r;
    wr_data   = rd_data;
    rd_en     = 1'b0;
    rd_addr   = cur_r;
    unique case (state_r)
      // clearing pass after reset
      ST_INIT: begin
        wr_en             = 1'b1;
        wr_addr           = clr_r;
        wr_data.free_mark = (clr_r != '0);
        wr_data.end_mark  = (clr_r == '0);
        wr_data.next_link = RESET_LINK;
        if (clr_r == LAST_IDX) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_nxt = command;
          cur_nxt = head_idx;
          cnt_nxt = link_count;
          ptr_nxt = '0;
          n_nxt   = '0;
          unique case (command)
            CMD_ALLOC, CMD_APPEND: state_nxt = ST_SCAN;
            CMD_FREE:              state_nxt = ST_START;
            default: begin
              if (link_count == '0) begin
                rstat_nxt = STAT_OK;
                ridx_nxt  = head_ext[7:0];
                state_nxt = ST_DONE;
              end else begin
                state_nxt = ST_START;
              end
            end
          endcase
        end
      end
      // lowest free entry, one read issued per cycle
      ST_SCAN: begin
        if (rvld_r && rd_data.free_mark) begin
          wr_en             = 1'b1;
          wr_addr           = raddr_r;
          wr_data.free_mark = 1'b0;
          wr_data.end_mark  = 1'b1;
          fresh_nxt         = raddr_r;
          if (cmd_r == CMD_ALLOC) begin
            rstat_nxt = STAT_OK;
            ridx_nxt  = raddr_ext[7:0];
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_START;
          end
        end else if (ptr_r == ENTRIES_W) begin
          rstat_nxt = STAT_NOFREE;
          ridx_nxt  = '0;
          state_nxt = ST_DONE;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = ptr_r[IW-1:0];
          raddr_nxt = ptr_r[IW-1:0];
          ptr_nxt   = ptr_r + 1'b1;
          rvld_nxt  = 1'b1;
        end
      end
      // first read of the chain head
      ST_START: begin
        rd_en = 1'b1;
        n_nxt = '0;
        unique case (cmd_r)
          CMD_APPEND: state_nxt = ST_WALK;
          CMD_FREE:   state_nxt = ST_FREE;
          default:    state_nxt = ST_LOOK;
        endcase
      end
      // append: walk to chain end (or a full table of links), link the fresh entry there
      ST_WALK: begin
        if (rd_data.end_mark || (n_r == ENTRIES_W)) begin
          wr_en             = 1'b1;
          wr_data.end_mark  = 1'b0;
          wr_data.next_link = fresh_ext[7:0];
          rstat_nxt         = STAT_OK;
          ridx_nxt          = fresh_ext[7:0];
          state_nxt         = ST_DONE;
        end else begin
          cur_nxt = link_idx;
          n_nxt   = n_r + 1'b1;
          rd_en   = 1'b1;
          rd_addr = link_idx;
        end
      end
      // free: mark each visited entry free
      ST_FREE: begin
        wr_en             = 1'b1;
        wr_data.free_mark = 1'b1;
        if (rd_data.end_mark || (n_r == LAST_N)) begin
          rstat_nxt = STAT_OK;
          ridx_nxt  = '0;
          state_nxt = ST_DONE;
        end else begin
          cur_nxt = link_idx;
          n_nxt   = n_r + 1'b1;
          rd_en   = 1'b1;
          rd_addr = link_idx;
        end
      end
      // lookup: follow cnt_r links
      ST_LOOK: begin
        if (rd_data.end_mark) begin
          rstat_nxt = STAT_PAST;
          ridx_nxt  = '0;
          state_nxt = ST_DONE;
        end else if (cnt_r == 8'd1) begin
          rstat_nxt = STAT_OK;
          ridx_nxt  = cur_next_ext[7:0];
          state_nxt = ST_DONE;
        end else begin
          cur_nxt = link_idx;
          cnt_nxt = cnt_r - 1'b1;
          rd_en   = 1'b1;
          rd_addr = link_idx;
        end
      end
      ST_DONE: begin
        if (load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Result register
  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (res_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      clr_r       <= '0;
      rvld_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      rvld_r      <= rvld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    cur_r   <= cur_nxt;
    cnt_r   <= cnt_nxt;
    n_r     <= n_nxt;
    ptr_r   <= ptr_nxt;
    raddr_r <= raddr_nxt;
    fresh_r <= fresh_nxt;
    rstat_r <= rstat_nxt;
    ridx_r  <= ridx_nxt;
    if (load) begin
      out_stat_r <= rstat_r;
      out_idx_r  <= ridx_r;
    end
  end

  assign res_valid   = out_valid_r;
  assign status      = out_stat_r;
  assign entry_index = out_idx_r;

  // Checks
  a_init_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INIT) |-> !cmd_ready)
    else $error("command taken during clearing pass");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (load && (rstat_r != STAT_OK)) |-> (ridx_r == '0))
    else $error("error result with nonzero index");

  a_nofree_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (load && (rstat_r == STAT_NOFREE)) |-> ((cmd_r == CMD_ALLOC) || (cmd_r == CMD_APPEND)))
    else $error("no-free status on a command that does not allocate");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (res_valid && (state_r == ST_IDLE)))
    else $error("result load did not present a result");

endmodule

`default_nettype wire

// ----- src/fat_chain_manager.sv -----
// ----------------------------------------------------------------------------
// fat_chain_manager
// Allocation table chain manager: allocate, append, free and lookup commands.
// ----------------------------------------------------------------------------
// Usage:
//   Commands arrive on the in_ stream, one transfer per command; each
//   command gives exactly one result transfer on the out_ stream.
//   The table lives in one synchronous RAM (1 write, 1 read port).
//   Work per command, from accept to result ready:
//     allocate : free search over up to TABLE_ENTRIES entries, which
//                reads one entry per cycle from index 0 upward
//     append   : free search plus a walk of up to TABLE_ENTRIES links
//     free     : up to TABLE_ENTRIES chain entries, one per cycle
//     lookup   : walks link_count links, none when link_count is zero
//   One command is worked at a time; in_tready is high only when idle.
//   After reset a clearing pass writes every table entry, during which
//   no command is accepted.
//   The result sits in an output register; while the receiver stalls the
//   next command may still be accepted, and finishes once the register is
//   taken.
// ----------------------------------------------------------------------------
`default_nettype none

module fat_chain_manager
  import fcm_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // command stream
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // [1:0] command, [9:2] chain_head, [17:10] link_count, [23:18] zero
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // result stream
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // [1:0] status, [9:2] entry_index, [15:10] zero
  output logic [OUT_TDATA_W-1:0]      out_tdata
);

  localparam int IW = $clog2(TABLE_ENTRIES);

  logic              wr_en;
  logic [IW-1:0]     wr_addr;
  entry_t            wr_data;
  logic              rd_en;
  logic [IW-1:0]     rd_addr;
  entry_t            rd_data;
  logic [STAT_W-1:0] status;
  logic [BYTE_W-1:0] entry_index;

  // Sequencer
  fcm_ctrl #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (in_tvalid),
    .cmd_ready   (in_tready),
    .command     (in_tdata[1:0]),
    .chain_head  (in_tdata[9:2]),
    .link_count  (in_tdata[17:10]),
    .res_valid   (out_tvalid),
    .res_ready   (out_tready),
    .status      (status),
    .entry_index (entry_index),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data)
  );

  // Table memory
  fcm_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Result packing
  assign out_tdata = {6'd0, entry_index, status};

endmodule

`default_nettype wire

// ----- tb/sv/fat_chain_manager_checker.sv -----
// ----------------------------------------------------------------------------
// fat_chain_manager_checker
// Watches both streams of the chain manager, keeps its own copy of the
// allocation table, predicts one result per accepted command and compares
// each result transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module fat_chain_manager_checker
  import fcm_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  input  wire logic                   in_tready,
  // [1:0] command, [9:2] chain_head, [17:10] link_count, [23:18] zero
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  input  wire logic                   out_tvalid,
  input  wire logic                   out_tready,
  // [1:0] status, [9:2] entry_index, [15:10] zero
  input  wire logic [OUT_TDATA_W-1:0] out_tdata,
  output int                          mismatches,
  output int                          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ENTRIES = DEF_TABLE_ENTRIES;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [BYTE_W-1:0] entry_index;
  } outcome_t;

  // Shadow allocation table
  bit                is_free [ENTRIES];
  bit                is_end  [ENTRIES];
  logic [BYTE_W-1:0] link_of [ENTRIES];

  // Outcomes of accepted commands, oldest first
  outcome_t outcome_q[$];
  outcome_t want;
  logic [STAT_W-1:0] got_status;
  logic [BYTE_W-1:0] got_index;

  function automatic int unsigned wrap_slot(input int unsigned v);
    return v % ENTRIES;
  endfunction

  // Take the lowest free entry and make it a chain end
  function automatic bit claim_lowest(output int unsigned got);
    got = 0;
    for (int unsigned i = 0; i < ENTRIES; i++) begin
      if (is_free[i]) begin
        is_free[i] = 1'b0;
        is_end[i]  = 1'b1;
        got        = i;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Apply one command to the shadow table and return its result
  function automatic outcome_t apply_command(input logic [CMD_W-1:0]  cmd,
                                             input logic [BYTE_W-1:0] head,
                                             input logic [BYTE_W-1:0] count);
    outcome_t    res;
    int unsigned cur;
    int unsigned fresh;
    int unsigned n;
    res.status      = STAT_OK;
    res.entry_index = '0;
    cur             = wrap_slot(head);
    fresh           = 0;
    case (cmd)
      CMD_ALLOC: begin
        if (claim_lowest(fresh)) res.entry_index = fresh[BYTE_W-1:0];
        else res.status = STAT_NOFREE;
      end
      CMD_APPEND: begin
        // new entry is claimed first, so the walk may run through it
        if (claim_lowest(fresh)) begin
          n = 0;
          while (n < ENTRIES && !is_end[cur]) begin
            cur = wrap_slot(link_of[cur]);
            n++;
          end
          is_end[cur]     = 1'b0;
          link_of[cur]    = fresh[BYTE_W-1:0];
          res.entry_index = fresh[BYTE_W-1:0];
        end else begin
          res.status = STAT_NOFREE;
        end
      end
      CMD_FREE: begin
        // end marks and links stay as they are
        for (n = 0; n < ENTRIES; n++) begin
          is_free[cur] = 1'b1;
          if (is_end[cur]) break;
          cur = wrap_slot(link_of[cur]);
        end
      end
      CMD_LOOKUP: begin
        for (n = 0; n < count; n++) begin
          if (is_end[cur]) begin
            res.status = STAT_PAST;
            break;
          end
          cur = wrap_slot(link_of[cur]);
        end
        if (res.status == STAT_OK) res.entry_index = cur[BYTE_W-1:0];
      end
      default: ;
    endcase
    return res;
  endfunction

  // Predict on command transfers, compare on result transfers
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int unsigned i = 0; i < ENTRIES; i++) begin
        is_free[i] = (i != 0);
        is_end[i]  = (i == 0);
        link_of[i] = RESET_LINK;
      end
      outcome_q.delete();
      mismatches = 0;
      pending    = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got_status = out_tdata[STAT_W-1:0];
        got_index  = out_tdata[STAT_W +: BYTE_W];
        if (outcome_q.size() == 0) begin
          $display("%0t: result with nothing expected: status %0d entry_index %0d",
                   $time, got_status, got_index);
          mismatches++;
        end else begin
          want = outcome_q.pop_front();
          if (got_status !== want.status) begin
            $display("%0t: status mismatch: expected %0d actual %0d",
                     $time, want.status, got_status);
            mismatches++;
          end
          if (got_index !== want.entry_index) begin
            $display("%0t: entry_index mismatch: expected %0d actual %0d",
                     $time, want.entry_index, got_index);
            mismatches++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        outcome_q.push_back(apply_command(in_tdata[CMD_W-1:0],
                                          in_tdata[CMD_W +: BYTE_W],
                                          in_tdata[CMD_W+BYTE_W +: BYTE_W]));
      end
      pending = outcome_q.size();
    end
  end

endmodule

`default_nettype wire

// ----- tb/sv/fat_chain_manager_tb.sv -----
// ----------------------------------------------------------------------------
// fat_chain_manager_tb
// Drives allocate, append, free and lookup commands into the chain manager:
// a directed opening on reset state, cyclic chains and stale links, then
// random phases that grow, fill and drain the table. Both streams idle at
// random; the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
`default_nettype none

module fat_chain_manager_tb;
  import fcm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     CLK_HALF     = 6;
  localparam int     RESET_CYCLES = 8;
  localparam int     IDLE_PCT     = 35;
  localparam int     DRAIN_CYCLES = 2 * DEF_TABLE_ENTRIES + 64;
  localparam longint CYCLE_LIMIT  = 4_000_000;
  localparam int     PAD_W        = IN_TDATA_W - CMD_W - 2 * BYTE_W;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  // [1:0] command, [9:2] chain_head, [17:10] link_count, [23:18] zero
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // [1:0] status, [9:2] entry_index, [15:10] zero
  logic [OUT_TDATA_W-1:0] out_tdata;

  int          mismatches;
  int          pending;
  bit          steady   = 1'b0;  // no idling on either side while set
  int unsigned used_top = 1;     // rough top of the region holding chains
  longint      cycles   = 0;

  fat_chain_manager dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  fat_chain_manager_checker chain_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Run guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL fat_chain_manager");
      $finish;
    end
  end

  // Result side back-pressure
  always @(negedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // One command transfer; called and returns at a falling edge
  task automatic send_command(input logic [CMD_W-1:0]  cmd,
                              input logic [BYTE_W-1:0] head,
                              input logic [BYTE_W-1:0] count);
    if (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{PAD_W{1'b0}}, count, head, cmd};
    // tready is stable between edges; the transfer lands on the next rise
    while (!in_tready) @(negedge clk);
    @(negedge clk);
    if ((cmd == CMD_ALLOC || cmd == CMD_APPEND) && used_top < 255) used_top++;
  endtask

  // Hold off commands until every result has been taken
  task automatic settle;
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    @(negedge clk);
  endtask

  // Mostly heads inside the used region, some anywhere in the table
  function automatic logic [BYTE_W-1:0] pick_head;
    if ($urandom_range(99) < 80) return BYTE_W'($urandom_range(used_top, 0));
    return BYTE_W'($urandom_range(255, 0));
  endfunction

  // Mostly short walks, some over the full count range
  function automatic logic [BYTE_W-1:0] pick_count;
    if ($urandom_range(99) < 70) return BYTE_W'($urandom_range(12, 0));
    return BYTE_W'($urandom_range(255, 0));
  endfunction

  // Random commands with the given percentages; the rest are lookups
  task automatic random_run(input int unsigned n, input int unsigned w_alloc,
                            input int unsigned w_append, input int unsigned w_free);
    int unsigned       r;
    logic [CMD_W-1:0]  cmd;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < w_alloc) cmd = CMD_ALLOC;
      else if (r < w_alloc + w_append) cmd = CMD_APPEND;
      else if (r < w_alloc + w_append + w_free) cmd = CMD_FREE;
      else cmd = CMD_LOOKUP;
      send_command(cmd, pick_head(), pick_count());
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // Reset state: entry 0 is a one-entry chain, free entries link to 1
    send_command(CMD_LOOKUP, 8'd0,   8'd0);
    send_command(CMD_LOOKUP, 8'd0,   8'd1);
    send_command(CMD_LOOKUP, 8'd255, 8'd255);
    // free over stale links that loop on entry 1
    send_command(CMD_FREE,   8'd255, 8'd0);
    send_command(CMD_ALLOC,  8'd0,   8'd255);
    send_command(CMD_APPEND, 8'd1,   8'd0);
    send_command(CMD_APPEND, 8'd0,   8'd0);
    send_command(CMD_LOOKUP, 8'd0,   8'd2);
    send_command(CMD_LOOKUP, 8'd0,   8'd1);
    // entry 0 may be freed and handed out again
    send_command(CMD_FREE,   8'd0,   8'd0);
    send_command(CMD_ALLOC,  8'd0,   8'd0);
    send_command(CMD_FREE,   8'd1,   8'd0);
    // walk from a free entry runs into the entry just claimed: self loop
    send_command(CMD_APPEND, 8'd5,   8'd0);
    send_command(CMD_LOOKUP, 8'd1,   8'd255);
    // append on a cyclic chain stops after a full table of links
    send_command(CMD_APPEND, 8'd1,   8'd0);
    send_command(CMD_LOOKUP, 8'd128, 8'd128);
    send_command(CMD_FREE,   8'd1,   8'd0);
    send_command(CMD_ALLOC,  8'd170, 8'd85);
    send_command(CMD_APPEND, 8'd85,  8'd170);
    send_command(CMD_LOOKUP, 8'd2,   8'd3);
    send_command(CMD_FREE,   8'd254, 8'd0);
    send_command(CMD_ALLOC,  8'd0,   8'd0);
    settle();

    // grow chains, then fill the table until claims fail
    random_run(500, 20, 35, 15);
    random_run(350, 30, 55, 3);
    settle();
    // drain, then mixed traffic with a stretch of no idling
    random_run(250, 10, 10, 50);
    steady = 1'b1;
    random_run(300, 20, 35, 15);
    steady = 1'b0;
    random_run(330, 20, 35, 15);

    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("PASS fat_chain_manager");
    end else begin
      $display("FAIL fat_chain_manager");
    end
    $finish;
  end

endmodule

`default_nettype wire
